// ===== rtl/fqet_pkg.sv =====
// Package for the forced quadratic escape-time block: formats, register
// indexes, reset values and the quarter-wave cosine table builder.
// No dependencies.
package fqet_pkg;

  // Cosine table geometry
  localparam int COS_TABLE_BITS = 10;
  localparam int TBL_N          = 1 << COS_TABLE_BITS;
  localparam int ROM_ADDR_W     = COS_TABLE_BITS + 1;
  localparam int ROM_DATA_W     = 31;  // Q1.30, 0 .. 2^30

  // Datapath widths
  localparam int IN_W   = 32;  // Q8.24 inputs and coefficients
  localparam int X_W    = 40;  // Q16.24 working registers
  localparam int SUM_W  = 48;  // update sum before saturation
  localparam int PROD_W = 64;
  localparam int CNT_W  = 16;
  localparam int PH_W   = 32;

  localparam logic signed [SUM_W-1:0] X_MAX = SUM_W'(64'sd549755813887);
  localparam logic signed [SUM_W-1:0] X_MIN = -SUM_W'(64'sd549755813888);
  localparam logic signed [X_W-1:0]   X_BOUND_POS = X_W'(64'sd1677721600);
  localparam logic signed [X_W-1:0]   X_BOUND_NEG = -X_W'(64'sd1677721600);
  localparam logic [PROD_W-1:0]       ESC_SQ_LIM  = 64'd10000 << 48;

  localparam logic signed [PROD_W-1:0] HALF_Q24 = 64'sd1 << 23;
  localparam logic signed [PROD_W-1:0] HALF_Q30 = 64'sd1 << 29;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_A_REAL       = 3'd0,
    CFG_A_IMAG       = 3'd1,
    CFG_FORCING_REAL = 3'd2,
    CFG_FORCING_IMAG = 3'd3,
    CFG_START_PHASE  = 3'd4,
    CFG_PHASE_STEP   = 3'd5,
    CFG_MAX_ITER     = 3'd6
  } cfg_idx_t;

  localparam logic signed [IN_W-1:0] RST_A_REAL       = 32'sd13673431;
  localparam logic signed [IN_W-1:0] RST_A_IMAG       = 32'sd0;
  localparam logic signed [IN_W-1:0] RST_FORCING_REAL = 32'sd7046431;
  localparam logic signed [IN_W-1:0] RST_FORCING_IMAG = 32'sd0;
  localparam logic [PH_W-1:0]        RST_START_PHASE  = 32'd0;
  localparam logic [PH_W-1:0]        RST_PHASE_STEP   = 32'd2654435769;
  localparam logic [CNT_W-1:0]       RST_MAX_ITER     = 16'd500;

  // Lookup request from the sequencer to the cosine unit
  typedef struct packed {
    logic            en;
    logic [PH_W-1:0] phase;
  } cos_req_t;

  typedef logic [ROM_DATA_W-1:0] cos_rom_t [0:TBL_N];

  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;
  localparam longint unsigned TAYLOR_DIV [0:7] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240
  };

  // cos(pi/2 * k / TBL_N) in Q1.30 by a truncated Taylor series, clamped
  function automatic cos_rom_t cos_rom_build();
    cos_rom_t          rom;
    longint unsigned   t;
    longint unsigned   t2;
    longint unsigned   term;
    longint            sum;
    for (int k = 0; k <= TBL_N; k++) begin
      t    = (PI_HALF_Q30 * longint'(k)) >> COS_TABLE_BITS;
      t2   = (t * t) >> 30;
      term = ONE_Q30;
      sum  = longint'(ONE_Q30);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * t2) >> 30) / TAYLOR_DIV[n-1];
        if ((n % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > longint'(ONE_Q30)) begin
        sum = longint'(ONE_Q30);
      end
      rom[k] = ROM_DATA_W'(sum);
    end
    return rom;
  endfunction

endpackage

// ===== rtl/fqet_cos_rom.sv =====
// Quarter-wave cosine unit: mirrors the phase into a table address, reads
// the ROM (registered) and applies the quadrant sign. Uses fqet_pkg.
module fqet_cos_rom (
  input  logic                            clk,
  input  fqet_pkg::cos_req_t              req,
  output logic signed [fqet_pkg::IN_W-1:0] cos_val
);

  localparam fqet_pkg::cos_rom_t COS_ROM = fqet_pkg::cos_rom_build();

  logic [1:0]                            quad;
  logic [fqet_pkg::COS_TABLE_BITS-1:0]   idx;
  logic [fqet_pkg::ROM_ADDR_W-1:0]       addr;
  logic [fqet_pkg::ROM_DATA_W-1:0]       mag_q;
  logic                                  neg_q;

  assign quad = req.phase[fqet_pkg::PH_W-1 -: 2];
  assign idx  = req.phase[fqet_pkg::PH_W-3 -: fqet_pkg::COS_TABLE_BITS];

  // odd quadrants read the table backwards
  always_comb begin
    if (quad[0]) begin
      addr = fqet_pkg::ROM_ADDR_W'(fqet_pkg::TBL_N) - {1'b0, idx};
    end else begin
      addr = {1'b0, idx};
    end
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      mag_q <= COS_ROM[addr];
      neg_q <= quad[1] ^ quad[0];
    end
    if (neg_q) begin
      cos_val <= -$signed({1'b0, mag_q});
    end else begin
      cos_val <= $signed({1'b0, mag_q});
    end
  end

endmodule

// ===== rtl/forced_quadratic_escape_time.sv =====
// Forced quadratic escape-time iterator: one shared 32x32 multiplier under a
// one-hot sequencer. Uses fqet_pkg and fqet_cos_rom.
// Step order: each orbit step runs S_SQRE, S_SQIM, S_CROSS, S_FRE, S_FIM and
// S_UPD (five products on the one multiplier plus the update). The done strobe
// is registered from an S_SQRE exit (limit or large component) or an S_CROSS
// exit (square-sum escape). busy stays high until the strobe cycle, in which
// a new start is taken. The result receiver cannot stall; done lasts one cycle.
// Reset (rst, synchronous): clears the sequencer and strobe, loads register
// defaults. The cosine ROM is constant and needs no clearing.
module forced_quadratic_escape_time (
  input  logic                              clk,
  input  logic                              rst,
  // request channel
  input  logic                              start,
  output logic                              busy,
  input  logic signed [fqet_pkg::IN_W-1:0]  start_re,
  input  logic signed [fqet_pkg::IN_W-1:0]  start_im,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [2:0]                        cfg_index,
  input  logic [31:0]                       cfg_data,
  // result
  output logic                              done,
  output logic                              escaped,
  output logic [fqet_pkg::CNT_W-1:0]        iter_count
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SQRE  = 7'b0000010,  // limit and bound test, re*re
    S_SQIM  = 7'b0000100,  // im*im
    S_CROSS = 7'b0001000,  // square-sum test, re*im
    S_FRE   = 7'b0010000,  // forcing_real * cos
    S_FIM   = 7'b0100000,  // forcing_imag * cos
    S_UPD   = 7'b1000000   // new x, advance phase and count
  } state_t;

  state_t state;

  // configuration registers
  logic signed [fqet_pkg::IN_W-1:0]  a_real, a_imag, forcing_real, forcing_imag;
  logic [fqet_pkg::PH_W-1:0]         start_phase, phase_step;
  logic [fqet_pkg::CNT_W-1:0]        max_iter;

  // orbit state
  logic signed [fqet_pkg::X_W-1:0]   re, im;
  logic [fqet_pkg::PH_W-1:0]         phase;
  logic [fqet_pkg::CNT_W-1:0]        step_cnt;

  // product registers
  logic signed [fqet_pkg::PROD_W-1:0] rr, ii, rx, fr, fi;

  // shared multiplier
  logic signed [fqet_pkg::IN_W-1:0]   mul_a, mul_b;
  logic signed [fqet_pkg::PROD_W-1:0] prod;

  logic signed [fqet_pkg::IN_W-1:0]   cos_val;
  fqet_pkg::cos_req_t                 cos_req;

  logic                               big;
  logic [fqet_pkg::PROD_W-1:0]        mag_sq;
  logic signed [fqet_pkg::PROD_W-1:0] sq_re_full, sq_im_full, f_re_full, f_im_full;
  logic signed [fqet_pkg::SUM_W-1:0]  sum_re, sum_im;
  logic signed [fqet_pkg::X_W-1:0]    re_next, im_next;

  assign busy      = (state != S_IDLE);
  // Hold register writes off while a request is in flight or being taken
  assign cfg_ready = !busy && !start;

  // Look up the cosine at the start of each step; it is ready by S_FRE.
  assign cos_req.en    = (state == S_SQRE);
  assign cos_req.phase = phase;

  fqet_cos_rom u_cos (
    .clk     (clk),
    .req     (cos_req),
    .cos_val (cos_val)
  );

  // Operand select for the shared multiplier
  always_comb begin
    unique case (state)
      S_SQRE:  begin mul_a = re[fqet_pkg::IN_W-1:0]; mul_b = re[fqet_pkg::IN_W-1:0]; end
      S_SQIM:  begin mul_a = im[fqet_pkg::IN_W-1:0]; mul_b = im[fqet_pkg::IN_W-1:0]; end
      S_CROSS: begin mul_a = re[fqet_pkg::IN_W-1:0]; mul_b = im[fqet_pkg::IN_W-1:0]; end
      S_FRE:   begin mul_a = forcing_real;           mul_b = cos_val;                end
      S_FIM:   begin mul_a = forcing_imag;           mul_b = cos_val;                end
      default: begin mul_a = re[fqet_pkg::IN_W-1:0]; mul_b = im[fqet_pkg::IN_W-1:0]; end
    endcase
  end

  assign prod = fqet_pkg::PROD_W'(mul_a) * fqet_pkg::PROD_W'(mul_b);

  // A component at or past 100 escapes without squaring; below that both
  // components fit the 32-bit multiplier operands.
  assign big = (re >= fqet_pkg::X_BOUND_POS) || (re <= fqet_pkg::X_BOUND_NEG) ||
               (im >= fqet_pkg::X_BOUND_POS) || (im <= fqet_pkg::X_BOUND_NEG);

  assign mag_sq = $unsigned(rr) + $unsigned(ii);

  // Round products to Q24 (half up, floor), then x = a - x^2 + eps*cos
  always_comb begin
    sq_re_full = (rr - ii + fqet_pkg::HALF_Q24) >>> 24;
    sq_im_full = ((rx <<< 1) + fqet_pkg::HALF_Q24) >>> 24;
    f_re_full  = (fr + fqet_pkg::HALF_Q30) >>> 30;
    f_im_full  = (fi + fqet_pkg::HALF_Q30) >>> 30;
    sum_re = fqet_pkg::SUM_W'(a_real) - sq_re_full[fqet_pkg::SUM_W-1:0]
           + f_re_full[fqet_pkg::SUM_W-1:0];
    sum_im = fqet_pkg::SUM_W'(a_imag) - sq_im_full[fqet_pkg::SUM_W-1:0]
           + f_im_full[fqet_pkg::SUM_W-1:0];
    // saturate to Q16.24
    if (sum_re > fqet_pkg::X_MAX) begin
      re_next = fqet_pkg::X_MAX[fqet_pkg::X_W-1:0];
    end else if (sum_re < fqet_pkg::X_MIN) begin
      re_next = fqet_pkg::X_MIN[fqet_pkg::X_W-1:0];
    end else begin
      re_next = sum_re[fqet_pkg::X_W-1:0];
    end
    if (sum_im > fqet_pkg::X_MAX) begin
      im_next = fqet_pkg::X_MAX[fqet_pkg::X_W-1:0];
    end else if (sum_im < fqet_pkg::X_MIN) begin
      im_next = fqet_pkg::X_MIN[fqet_pkg::X_W-1:0];
    end else begin
      im_next = sum_im[fqet_pkg::X_W-1:0];
    end
  end

  // Configuration registers: written only while the block is idle
  always_ff @(posedge clk) begin
    if (rst) begin
      a_real       <= fqet_pkg::RST_A_REAL;
      a_imag       <= fqet_pkg::RST_A_IMAG;
      forcing_real <= fqet_pkg::RST_FORCING_REAL;
      forcing_imag <= fqet_pkg::RST_FORCING_IMAG;
      start_phase  <= fqet_pkg::RST_START_PHASE;
      phase_step   <= fqet_pkg::RST_PHASE_STEP;
      max_iter     <= fqet_pkg::RST_MAX_ITER;
    end else if (cfg_valid && cfg_ready) begin
      unique case (fqet_pkg::cfg_idx_t'(cfg_index))
        fqet_pkg::CFG_A_REAL:       a_real       <= $signed(cfg_data);
        fqet_pkg::CFG_A_IMAG:       a_imag       <= $signed(cfg_data);
        fqet_pkg::CFG_FORCING_REAL: forcing_real <= $signed(cfg_data);
        fqet_pkg::CFG_FORCING_IMAG: forcing_imag <= $signed(cfg_data);
        fqet_pkg::CFG_START_PHASE:  start_phase  <= cfg_data;
        fqet_pkg::CFG_PHASE_STEP:   phase_step   <= cfg_data;
        fqet_pkg::CFG_MAX_ITER:     max_iter     <= cfg_data[fqet_pkg::CNT_W-1:0];
        default: ;  // index outside the register list: drop the write
      endcase
    end
  end

  // Sequencer and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_SQRE;
          end
        end
        S_SQRE: begin
          // limit reached, or a component already far out: finish
          if ((step_cnt >= max_iter) || big) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_SQIM;
          end
        end
        S_SQIM: state <= S_CROSS;
        S_CROSS: begin
          if (mag_sq >= fqet_pkg::ESC_SQ_LIM) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_FRE;
          end
        end
        S_FRE:   state <= S_FIM;
        S_FIM:   state <= S_UPD;
        S_UPD:   state <= S_SQRE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          re       <= fqet_pkg::X_W'(start_re);
          im       <= fqet_pkg::X_W'(start_im);
          phase    <= start_phase;
          step_cnt <= '0;
        end
      end
      S_SQRE: begin
        rr <= prod;
        // limit test has priority over the escape test
        if (step_cnt >= max_iter) begin
          escaped    <= 1'b0;
          iter_count <= '0;
        end else begin
          escaped    <= 1'b1;
          iter_count <= step_cnt;
        end
      end
      S_SQIM:  ii <= prod;
      S_CROSS: begin
        rx         <= prod;
        escaped    <= 1'b1;
        iter_count <= step_cnt;
      end
      S_FRE:   fr <= prod;
      S_FIM:   fi <= prod;
      S_UPD: begin
        re       <= re_next;
        im       <= im_next;
        phase    <= phase + phase_step;
        step_cnt <= step_cnt + 1'b1;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------

  // A result only leaves from one of the two exit points of the step loop
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_SQRE) || ($past(state) == S_CROSS))
    else $error("done without an exit from the step loop");

  // Not escaped always reports a zero count
  a_noesc_zero: assert property (@(posedge clk) disable iff (rst)
    done && !escaped |-> iter_count == '0)
    else $error("non-escaped result with nonzero count");

  // An escape count stays below the limit
  a_esc_limit: assert property (@(posedge clk) disable iff (rst)
    done && escaped |-> iter_count < max_iter)
    else $error("escape count at or above the limit");

  // An accepted request makes the block busy on the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  // The step counter never passes the limit while iterating
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_UPD |-> step_cnt < max_iter)
    else $error("step counter ran past the limit");

endmodule
